@@ hdl/ffha_pkg.sv @@
// Shared types, constants and header helpers for the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int ADDR_W     = 12;
	localparam int POS_W      = ADDR_W + 1;
	localparam int DLEN_W     = 21;
	localparam int SUM_W      = 22;
	localparam int DATA_W     = 8;

	localparam logic [SUM_W-1:0] HEAP_SUM  = SUM_W'(HEAP_BYTES);
	localparam logic [SUM_W-1:0] LIM_ONE   = SUM_W'(64);
	localparam logic [SUM_W-1:0] LIM_TWO   = SUM_W'(8192);
	localparam logic [SUM_W-1:0] LIM_TWO_T = SUM_W'(8193);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;
	localparam logic [1:0] OP_GC      = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic              has_block;
		logic [ADDR_W-1:0] block_address;
		logic [ADDR_W-1:0] old_size;
		logic [ADDR_W-1:0] new_size;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic              ok;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [1:0] hlen_for_data(input logic [SUM_W-1:0] len);
		logic [1:0] h;
		begin
			if (len < LIM_ONE) h = 2'd1;
			else if (len < LIM_TWO) h = 2'd2;
			else h = 2'd3;
			return h;
		end
	endfunction

	function automatic logic [1:0] hlen_for_total(input logic [SUM_W-1:0] total);
		logic [1:0] h;
		begin
			if (total <= LIM_ONE) h = 2'd1;
			else if (total <= LIM_TWO_T) h = 2'd2;
			else h = 2'd3;
			return h;
		end
	endfunction

	function automatic logic [DATA_W-1:0] hdr_byte(input logic [1:0] k, input logic busy,
			input logic [1:0] hlen, input logic [DLEN_W-1:0] dlen);
		logic [DATA_W-1:0] b;
		begin
			case (k)
				2'd0: b = {busy, (hlen > 2'd1), dlen[5:0]};
				2'd1: b = {(hlen > 2'd2), dlen[12:6]};
				default: b = dlen[20:13];
			endcase
			return b;
		end
	endfunction

	localparam logic [1:0]        INIT_H    = hlen_for_total(HEAP_SUM);
	localparam logic [DLEN_W-1:0] INIT_DLEN = DLEN_W'(HEAP_BYTES) - DLEN_W'(INIT_H);

endpackage

@@ hdl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: store, sequencer and result register.
//
// Requests arrive on req (req_valid/req_stall) and carry an operation kind:
// alloc, free, realloc or coalesce. Each request gives exactly one response
// on rsp (rsp_valid/rsp_stall) with ok and the data offset of a new block (zero when none is made).
// A transaction is taken on a clock edge with valid high and stall low.
// Requests are handled one at a time; req_stall is high while one is in work.
// The time an operation takes depends on the heap contents: walking a block passes
// a loop and a check state plus one store read per header byte, a header is written
// and the data zeroed one byte at a time, and the realloc move reads and then
// writes each byte, all through the single store port. After reset the store
// is swept once to build one free block with zeroed data; req_stall stays
// high during the sweep.
// The response sits in an output register; a stalled response holds there
// while the sequencer may already accept and work on the next request.
module first_fit_heap_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffha_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffha_pkg::rsp_t rsp
);
	import ffha_pkg::*;

	mem_req_t          mem;
	logic [DATA_W-1:0] rdata;
	logic              idle, done, take;
	rsp_t              seq_rsp;

	ffha_ram #(
		.DEPTH    (HEAP_BYTES),
		.ADDR_BITS(ADDR_W),
		.DATA_BITS(DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (mem.we),
		.addr (mem.addr),
		.wdata(mem.wdata),
		.rdata(rdata)
	);

	ffha_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.idle     (idle),
		.mem      (mem),
		.rdata    (rdata),
		.done     (done),
		.rsp      (seq_rsp),
		.take     (take)
	);

	assign req_stall = !idle;
	// load when the register is empty or being drained this cycle
	assign take = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (take) begin
			rsp_valid <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (take && done) begin
			rsp <= seq_rsp;
		end
	end

endmodule

@@ hdl/ffha_ram.sv @@
// Single-port synchronous byte store with registered read data.
module ffha_ram #(
	parameter int DEPTH     = 4096,
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ hdl/ffha_seq.sv @@
// Operation sequencer: walks headers, writes headers, zeroes and copies through the store.
module ffha_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  ffha_pkg::req_t                 req,
	output logic                           idle,
	output ffha_pkg::mem_req_t             mem,
	input  logic [ffha_pkg::DATA_W-1:0]    rdata,
	output logic                           done,
	output ffha_pkg::rsp_t                 rsp,
	input  logic                           take
);
	import ffha_pkg::*;

	localparam logic [5:0] S_CLR     = 6'd0;
	localparam logic [5:0] S_IDLE    = 6'd1;
	localparam logic [5:0] S_GH0     = 6'd2;
	localparam logic [5:0] S_GH1     = 6'd3;
	localparam logic [5:0] S_GH2     = 6'd4;
	localparam logic [5:0] S_GH3     = 6'd5;
	localparam logic [5:0] S_PH      = 6'd6;
	localparam logic [5:0] S_ZR      = 6'd7;
	localparam logic [5:0] S_MF0     = 6'd8;
	localparam logic [5:0] S_MF1     = 6'd9;
	localparam logic [5:0] S_FJ0     = 6'd10;
	localparam logic [5:0] S_FJ1     = 6'd11;
	localparam logic [5:0] S_FJ2     = 6'd12;
	localparam logic [5:0] S_AL_LOOP = 6'd13;
	localparam logic [5:0] S_AL_CHK  = 6'd14;
	localparam logic [5:0] S_AL_Z    = 6'd15;
	localparam logic [5:0] S_AL_J    = 6'd16;
	localparam logic [5:0] S_AL_OK   = 6'd17;
	localparam logic [5:0] S_AL_FAIL = 6'd18;
	localparam logic [5:0] S_FR0     = 6'd19;
	localparam logic [5:0] S_FR_OK   = 6'd20;
	localparam logic [5:0] S_GC_LOOP = 6'd21;
	localparam logic [5:0] S_GC_CHK  = 6'd22;
	localparam logic [5:0] S_GC_J    = 6'd23;
	localparam logic [5:0] S_GC_JC   = 6'd24;
	localparam logic [5:0] S_GC_MF   = 6'd25;
	localparam logic [5:0] S_GC_NEXT = 6'd26;
	localparam logic [5:0] S_GC_DONE = 6'd27;
	localparam logic [5:0] S_CP0     = 6'd28;
	localparam logic [5:0] S_CP_RD   = 6'd29;
	localparam logic [5:0] S_CP_WR   = 6'd30;
	localparam logic [5:0] S_FIN     = 6'd31;

	logic [5:0] state_q, ret_q, fj_ret_q, mf_ret_q;

	logic [1:0]        op_q;
	logic              have_q, retry_q;
	logic [ADDR_W-1:0] addr_q, osz_q, nsz_q, res_q;
	logic              ok_q;

	logic [POS_W-1:0]  i_q, j_q, gh_a_q;
	logic              h_busy_q;
	logic [1:0]        h_hlen_q;
	logic [DLEN_W-1:0] h_dlen_q;
	logic              oob_q;

	logic [POS_W-1:0]  ph_a_q;
	logic              ph_busy_q;
	logic [1:0]        ph_hlen_q, ph_k_q;
	logic [DLEN_W-1:0] ph_dlen_q;

	logic [POS_W-1:0]  z_ptr_q, z_end_q;
	logic [POS_W-1:0]  mf_start_q, mf_total_q;
	logic [POS_W-1:0]  cp_src_q, cp_dst_q, cp_n_q;
	logic              cp_back_q;

	logic [DATA_W-1:0] rd;
	logic [SUM_W-1:0]  t_sum, i_ext, j_ext, i_plus_t, j_plus_t;
	logic [1:0]        hs, mf_h, fr_h;
	logic [SUM_W-1:0]  need, rest, ph_wa, fj_n, rd_pos;
	logic              fit;
	logic [SUM_W-1:0]  addr_ext, osz_ext, nsz_ext, res_ext, cp_m, cp_n1, cp_n2;

	function automatic logic [POS_W-1:0] clip_pos(input logic [SUM_W-1:0] v);
		return (v > HEAP_SUM) ? POS_W'(HEAP_BYTES) : POS_W'(v);
	endfunction

	assign rd       = oob_q ? '0 : rdata;
	assign t_sum    = SUM_W'(h_hlen_q) + SUM_W'(h_dlen_q);
	assign i_ext    = SUM_W'(i_q);
	assign j_ext    = SUM_W'(j_q);
	assign i_plus_t = i_ext + t_sum;
	assign j_plus_t = j_ext + t_sum;
	assign addr_ext = SUM_W'(addr_q);
	assign osz_ext  = SUM_W'(osz_q);
	assign nsz_ext  = SUM_W'(nsz_q);
	assign res_ext  = SUM_W'(res_q);
	assign hs       = hlen_for_data(nsz_ext);
	assign need     = SUM_W'(hs) + nsz_ext;
	assign fit      = !h_busy_q && (need <= t_sum);
	assign rest     = t_sum - need;
	assign ph_wa    = SUM_W'(ph_a_q) + SUM_W'(ph_k_q);
	assign mf_h     = hlen_for_total(SUM_W'(mf_total_q));
	assign fj_n     = SUM_W'(mf_start_q) + SUM_W'(mf_total_q);
	assign fr_h     = hlen_for_data(osz_ext);

	// copy length: min of sizes, clipped at the end of the store on both sides
	assign cp_m  = (osz_q < nsz_q) ? osz_ext : nsz_ext;
	assign cp_n1 = (addr_ext + cp_m > HEAP_SUM) ? (HEAP_SUM - addr_ext) : cp_m;
	assign cp_n2 = (res_ext + cp_n1 > HEAP_SUM) ? (HEAP_SUM - res_ext) : cp_n1;

	always_comb begin
		rd_pos    = '0;
		mem.we    = 1'b0;
		mem.wdata = '0;
		case (state_q)
			S_GH0:   rd_pos = SUM_W'(gh_a_q);
			S_GH1:   rd_pos = rd[6] ? SUM_W'(gh_a_q) + SUM_W'(1) : '0;
			S_GH2:   rd_pos = rd[7] ? SUM_W'(gh_a_q) + SUM_W'(2) : '0;
			S_FJ0:   rd_pos = fj_n;
			S_CP_RD: rd_pos = SUM_W'(cp_src_q);
			default: rd_pos = '0;
		endcase
		mem.addr = rd_pos[ADDR_W-1:0];
		case (state_q)
			S_CLR: begin
				mem.we   = 1'b1;
				mem.addr = z_ptr_q[ADDR_W-1:0];
				if (z_ptr_q < POS_W'(INIT_H))
					mem.wdata = hdr_byte(z_ptr_q[1:0], 1'b0, INIT_H, INIT_DLEN);
			end
			S_PH: begin
				mem.we    = ph_wa < HEAP_SUM;
				mem.addr  = ph_wa[ADDR_W-1:0];
				mem.wdata = hdr_byte(ph_k_q, ph_busy_q, ph_hlen_q, ph_dlen_q);
			end
			S_ZR: begin
				mem.we   = z_ptr_q < z_end_q;
				mem.addr = z_ptr_q[ADDR_W-1:0];
			end
			S_CP_WR: begin
				mem.we    = 1'b1;
				mem.addr  = cp_dst_q[ADDR_W-1:0];
				mem.wdata = rdata;
			end
			default: ;
		endcase
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_FIN;
	assign rsp.result_address = res_q;
	assign rsp.ok             = ok_q;

	always_ff @(posedge clk) begin
		oob_q <= rd_pos >= HEAP_SUM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			z_ptr_q <= '0;
			ph_k_q  <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					z_ptr_q <= z_ptr_q + 1'b1;
					if (z_ptr_q == POS_W'(HEAP_BYTES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.kind;
						have_q  <= req.has_block && (SUM_W'(req.block_address) < HEAP_SUM);
						addr_q  <= req.block_address;
						osz_q   <= req.old_size;
						nsz_q   <= req.new_size;
						retry_q <= req.kind != OP_REALLOC;
						i_q     <= '0;
						case (req.kind)
							OP_ALLOC:   state_q <= S_AL_LOOP;
							OP_FREE:    state_q <= S_FR0;
							OP_REALLOC: state_q <= S_AL_LOOP;
							default:    state_q <= S_GC_LOOP;
						endcase
					end
				end
				// header fetch: one byte per cycle, follow continuation bits
				S_GH0: state_q <= S_GH1;
				S_GH1: begin
					h_busy_q <= rd[7];
					h_hlen_q <= 2'd1;
					h_dlen_q <= DLEN_W'(rd[5:0]);
					state_q  <= rd[6] ? S_GH2 : ret_q;
				end
				S_GH2: begin
					h_hlen_q       <= 2'd2;
					h_dlen_q[12:6] <= rd[6:0];
					state_q        <= rd[7] ? S_GH3 : ret_q;
				end
				S_GH3: begin
					h_hlen_q        <= 2'd3;
					h_dlen_q[20:13] <= rd;
					state_q         <= ret_q;
				end
				S_PH: begin
					if (ph_k_q == ph_hlen_q - 2'd1) begin
						ph_k_q  <= '0;
						state_q <= ret_q;
					end else begin
						ph_k_q <= ph_k_q + 2'd1;
					end
				end
				S_ZR: begin
					if (z_ptr_q < z_end_q) z_ptr_q <= z_ptr_q + 1'b1;
					else state_q <= ret_q;
				end
				S_MF0: begin
					ph_a_q    <= mf_start_q;
					ph_busy_q <= 1'b0;
					ph_hlen_q <= mf_h;
					ph_dlen_q <= DLEN_W'(mf_total_q) - DLEN_W'(mf_h);
					ret_q     <= S_MF1;
					state_q   <= S_PH;
				end
				S_MF1: begin
					z_ptr_q <= mf_start_q + POS_W'(mf_h);
					z_end_q <= clip_pos(fj_n);
					ret_q   <= mf_ret_q;
					state_q <= S_ZR;
				end
				S_FJ0: begin
					mf_ret_q <= fj_ret_q;
					state_q  <= (fj_n < HEAP_SUM) ? S_FJ1 : S_MF0;
				end
				S_FJ1: begin
					if (rd[7]) begin
						state_q <= S_MF0;
					end else begin
						gh_a_q  <= POS_W'(fj_n);
						ret_q   <= S_FJ2;
						state_q <= S_GH0;
					end
				end
				S_FJ2: begin
					if (fj_n + t_sum <= HEAP_SUM)
						mf_total_q <= POS_W'(SUM_W'(mf_total_q) + t_sum);
					state_q <= S_MF0;
				end
				S_AL_LOOP: begin
					if (i_ext >= HEAP_SUM) begin
						state_q <= S_AL_FAIL;
					end else begin
						gh_a_q  <= i_q;
						ret_q   <= S_AL_CHK;
						state_q <= S_GH0;
					end
				end
				S_AL_CHK: begin
					if (i_plus_t > HEAP_SUM) begin
						state_q <= S_AL_FAIL;
					end else if (fit) begin
						ph_a_q    <= i_q;
						ph_busy_q <= 1'b1;
						ph_hlen_q <= hs;
						ph_dlen_q <= DLEN_W'(nsz_q);
						ret_q     <= S_AL_Z;
						state_q   <= S_PH;
					end else begin
						i_q     <= POS_W'(i_plus_t);
						state_q <= S_AL_LOOP;
					end
				end
				S_AL_Z: begin
					z_ptr_q <= i_q + POS_W'(hs);
					z_end_q <= clip_pos(i_ext + need);
					ret_q   <= S_AL_J;
					state_q <= S_ZR;
				end
				S_AL_J: begin
					if (rest != '0) begin
						mf_start_q <= POS_W'(i_ext + need);
						mf_total_q <= POS_W'(rest);
						fj_ret_q   <= S_AL_OK;
						state_q    <= S_FJ0;
					end else begin
						state_q <= S_AL_OK;
					end
				end
				S_AL_OK: begin
					res_q   <= ADDR_W'(i_ext + SUM_W'(hs));
					ok_q    <= 1'b1;
					state_q <= (op_q == OP_REALLOC && have_q) ? S_CP0 : S_FIN;
				end
				S_AL_FAIL: begin
					if (!retry_q) begin
						retry_q <= 1'b1;
						i_q     <= '0;
						state_q <= S_GC_LOOP;
					end else begin
						res_q   <= '0;
						ok_q    <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FR0: begin
					if (addr_ext < SUM_W'(fr_h) || addr_ext + osz_ext > HEAP_SUM) begin
						if (op_q == OP_FREE) res_q <= '0;
						ok_q    <= op_q != OP_FREE;
						state_q <= S_FIN;
					end else begin
						mf_start_q <= POS_W'(addr_ext - SUM_W'(fr_h));
						mf_total_q <= POS_W'(SUM_W'(fr_h) + osz_ext);
						fj_ret_q   <= S_FR_OK;
						state_q    <= S_FJ0;
					end
				end
				S_FR_OK: begin
					if (op_q == OP_FREE) res_q <= '0;
					ok_q    <= 1'b1;
					state_q <= S_FIN;
				end
				S_GC_LOOP: begin
					if (i_ext >= HEAP_SUM) begin
						state_q <= S_GC_DONE;
					end else begin
						gh_a_q  <= i_q;
						ret_q   <= S_GC_CHK;
						state_q <= S_GH0;
					end
				end
				S_GC_CHK: begin
					if (i_plus_t > HEAP_SUM) begin
						state_q <= S_GC_DONE;
					end else if (h_busy_q) begin
						i_q     <= POS_W'(i_plus_t);
						state_q <= S_GC_LOOP;
					end else begin
						j_q     <= POS_W'(i_plus_t);
						state_q <= S_GC_J;
					end
				end
				S_GC_J: begin
					if (j_ext >= HEAP_SUM) begin
						state_q <= S_GC_MF;
					end else begin
						gh_a_q  <= j_q;
						ret_q   <= S_GC_JC;
						state_q <= S_GH0;
					end
				end
				S_GC_JC: begin
					if (h_busy_q || j_plus_t > HEAP_SUM) begin
						state_q <= S_GC_MF;
					end else begin
						j_q     <= POS_W'(j_plus_t);
						state_q <= S_GC_J;
					end
				end
				S_GC_MF: begin
					mf_start_q <= i_q;
					mf_total_q <= j_q - i_q;
					mf_ret_q   <= S_GC_NEXT;
					state_q    <= S_MF0;
				end
				S_GC_NEXT: begin
					i_q     <= j_q;
					state_q <= S_GC_LOOP;
				end
				S_GC_DONE: begin
					if (op_q == OP_REALLOC) begin
						i_q     <= '0;
						state_q <= S_AL_LOOP;
					end else begin
						res_q   <= '0;
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end
				end
				// overlap-safe move: copy downward when the target lies above the source
				S_CP0: begin
					if (cp_n2 == '0) begin
						state_q <= S_FR0;
					end else begin
						cp_n_q    <= POS_W'(cp_n2);
						cp_back_q <= res_q > addr_q;
						if (res_q > addr_q) begin
							cp_src_q <= POS_W'(addr_ext + cp_n2 - SUM_W'(1));
							cp_dst_q <= POS_W'(res_ext + cp_n2 - SUM_W'(1));
						end else begin
							cp_src_q <= POS_W'(addr_q);
							cp_dst_q <= POS_W'(res_q);
						end
						state_q <= S_CP_RD;
					end
				end
				S_CP_RD: state_q <= S_CP_WR;
				S_CP_WR: begin
					cp_src_q <= cp_back_q ? cp_src_q - 1'b1 : cp_src_q + 1'b1;
					cp_dst_q <= cp_back_q ? cp_dst_q - 1'b1 : cp_dst_q + 1'b1;
					cp_n_q   <= cp_n_q - 1'b1;
					state_q  <= (cp_n_q == POS_W'(1)) ? S_FR0 : S_CP_RD;
				end
				S_FIN: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !mem.we) else $error("store written while idle");
	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		done && take |=> idle) else $error("result handed off but sequencer not idle");
	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AL_CHK |-> h_hlen_q != 2'd0) else $error("decoded header length zero");
	a_copy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CP_RD |-> cp_n_q != '0) else $error("copy with empty count");
`endif

endmodule

@@ verif/tb_first_fit_heap_allocator.sv @@
// Self-checking testbench for the first-fit heap allocator with a byte-level heap predictor.
module tb_first_fit_heap_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int unsigned NUM_RANDOM  = 1650;
	localparam int unsigned DRAIN_WAIT  = 5000;
	localparam longint      CYCLE_LIMIT = 40_000_000;

	typedef struct {
		req_t item;
		bit   hold;
	} pending_t;

	typedef struct {
		int unsigned addr;
		int unsigned size;
	} live_blk_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	pending_t    pending_q[$];
	rsp_t        expected_rsp_q[$];
	live_blk_t   live_blocks[$];
	byte unsigned heap_img[HEAP_BYTES];
	int unsigned sent_cnt, rcvd_cnt, total_items;
	int unsigned mismatches;
	int unsigned n_alloc_ok, n_alloc_fail, n_free_ok, n_realloc_ok, n_gc;
	longint      cycles;

	// ---------------- heap predictor ----------------
	function automatic int unsigned peek(int unsigned a);
		return a < HEAP_BYTES ? int'(heap_img[a]) : 0;
	endfunction

	function automatic void poke(int unsigned a, int unsigned v);
		if (a < HEAP_BYTES) heap_img[a] = v[7:0];
	endfunction

	function automatic void clear_bytes(int unsigned from, int unsigned upto);
		if (upto > HEAP_BYTES) upto = HEAP_BYTES;
		for (int unsigned k = from; k < upto; k++) heap_img[k] = 8'h00;
	endfunction

	function automatic void read_hdr(input int unsigned a, output bit busy,
			output int unsigned hl, output int unsigned dl);
		int unsigned b0, b1;
		b0 = peek(a);
		busy = b0[7];
		hl = 1;
		dl = b0 & 'h3F;
		if (b0 & 'h40) begin
			b1 = peek(a + 1);
			hl = 2;
			dl |= (b1 & 'h7F) << 6;
			if (b1 & 'h80) begin
				hl = 3;
				dl |= peek(a + 2) << 13;
			end
		end
	endfunction

	function automatic void write_hdr(int unsigned a, bit busy, int unsigned hl,
			int unsigned dl);
		int unsigned b0, b1;
		b0 = (busy ? 'h80 : 0) | (dl & 'h3F);
		if (hl > 1) begin
			b1 = (dl >> 6) & 'h7F;
			b0 |= 'h40;
			if (hl > 2) begin
				b1 |= 'h80;
				poke(a + 2, (dl >> 13) & 'hFF);
			end
			poke(a + 1, b1);
		end
		poke(a, b0);
	endfunction

	function automatic int unsigned hdr_for_len(int unsigned len);
		return len < 64 ? 1 : (len < 8192 ? 2 : 3);
	endfunction

	function automatic int unsigned hdr_for_span(int unsigned span);
		return span <= 64 ? 1 : (span <= 8193 ? 2 : 3);
	endfunction

	function automatic void shape_free(int unsigned start, int unsigned span);
		int unsigned h;
		h = hdr_for_span(span);
		write_hdr(start, 1'b0, h, span - h);
		clear_bytes(start + h, start + span);
	endfunction

	function automatic void release_merge(int unsigned start, int unsigned span);
		int unsigned nxt, hl, dl;
		bit busy;
		nxt = start + span;
		if (nxt < HEAP_BYTES && !(peek(nxt) & 'h80)) begin
			read_hdr(nxt, busy, hl, dl);
			if (nxt + hl + dl <= HEAP_BYTES) span += hl + dl;
		end
		shape_free(start, span);
	endfunction

	function automatic bit first_fit(input int unsigned size, output int unsigned addr);
		int unsigned pos, hs, hl, dl, span, rest;
		bit busy;
		pos = 0;
		addr = 0;
		hs = hdr_for_len(size);
		while (pos < HEAP_BYTES) begin
			read_hdr(pos, busy, hl, dl);
			span = hl + dl;
			if (pos + span > HEAP_BYTES) break;
			if (!busy && hs + size <= span) begin
				rest = span - hs - size;
				write_hdr(pos, 1'b1, hs, size);
				clear_bytes(pos + hs, pos + hs + size);
				if (rest > 0) release_merge(pos + hs + size, rest);
				addr = pos + hs;
				return 1'b1;
			end
			pos += span;
		end
		return 1'b0;
	endfunction

	function automatic bit release_blk(int unsigned addr, int unsigned osz);
		int unsigned h;
		h = hdr_for_len(osz);
		if (addr < h || addr + osz > HEAP_BYTES) return 1'b0;
		release_merge(addr - h, h + osz);
		return 1'b1;
	endfunction

	function automatic void coalesce_all();
		int unsigned pos, nxt, hl, dl, span;
		bit busy, stop;
		pos = 0;
		while (pos < HEAP_BYTES) begin
			read_hdr(pos, busy, hl, dl);
			span = hl + dl;
			if (pos + span > HEAP_BYTES) break;
			if (busy) begin
				pos += span;
			end else begin
				nxt = pos + span;
				stop = 0;
				while (nxt < HEAP_BYTES && !stop) begin
					read_hdr(nxt, busy, hl, dl);
					if (busy || nxt + hl + dl > HEAP_BYTES) stop = 1;
					else nxt += hl + dl;
				end
				shape_free(pos, nxt - pos);
				pos = nxt;
			end
		end
	endfunction

	function automatic rsp_t predict_heap_op(req_t r);
		rsp_t        o;
		int unsigned res, n;
		bit          ok, have;
		byte unsigned tmp[];
		res = 0;
		ok = 0;
		case (r.kind)
			OP_ALLOC: ok = first_fit(r.new_size, res);
			OP_FREE: ok = release_blk(r.block_address, r.old_size);
			OP_REALLOC: begin
				have = r.has_block && r.block_address < HEAP_BYTES;
				ok = first_fit(r.new_size, res);
				if (!ok) begin
					coalesce_all();
					ok = first_fit(r.new_size, res);
				end
				if (ok && have) begin
					n = r.old_size < r.new_size ? r.old_size : r.new_size;
					if (r.block_address + n > HEAP_BYTES) n = HEAP_BYTES - r.block_address;
					if (res + n > HEAP_BYTES) n = HEAP_BYTES - res;
					// move through a scratch copy so overlap is handled
					tmp = new[n];
					for (int unsigned k = 0; k < n; k++) tmp[k] = heap_img[r.block_address + k];
					for (int unsigned k = 0; k < n; k++) heap_img[res + k] = tmp[k];
					void'(release_blk(r.block_address, r.old_size));
				end
			end
			default: begin
				coalesce_all();
				ok = 1;
			end
		endcase
		o.result_address = ok ? res[ADDR_W-1:0] : '0;
		o.ok = ok;
		return o;
	endfunction

	// ---------------- stimulus generation ----------------
	function automatic rsp_t issue(logic [1:0] kind, bit has, int unsigned addr,
			int unsigned osz, int unsigned nsz, bit hold);
		pending_t p;
		rsp_t     e;
		p.item.kind = kind;
		p.item.has_block = has;
		p.item.block_address = addr[ADDR_W-1:0];
		p.item.old_size = osz[ADDR_W-1:0];
		p.item.new_size = nsz[ADDR_W-1:0];
		p.hold = hold;
		e = predict_heap_op(p.item);
		pending_q.push_back(p);
		expected_rsp_q.push_back(e);
		total_items++;
		case (kind)
			OP_ALLOC: if (e.ok) n_alloc_ok++; else n_alloc_fail++;
			OP_FREE: if (e.ok) n_free_ok++;
			OP_REALLOC: if (e.ok) n_realloc_ok++;
			default: n_gc++;
		endcase
		return e;
	endfunction

	function automatic void alloc_tracked(int unsigned size, bit hold);
		rsp_t      e;
		live_blk_t b;
		e = issue(OP_ALLOC, $urandom_range(0, 1), $urandom, $urandom, size, hold);
		if (e.ok) begin
			b.addr = e.result_address;
			b.size = size;
			live_blocks.push_back(b);
		end
	endfunction

	function automatic void free_tracked(int unsigned idx, bit hold);
		rsp_t e;
		e = issue(OP_FREE, $urandom_range(0, 1), live_blocks[idx].addr,
			live_blocks[idx].size, $urandom, hold);
		live_blocks.delete(idx);
	endfunction

	function automatic void realloc_tracked(int unsigned idx, int unsigned size, bit hold);
		rsp_t e;
		e = issue(OP_REALLOC, 1'b1, live_blocks[idx].addr, live_blocks[idx].size, size, hold);
		if (e.ok) begin
			live_blocks[idx].addr = e.result_address;
			live_blocks[idx].size = size;
		end
	endfunction

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 70);
		if (r < 95) return $urandom_range(64, 400);
		return $urandom_range(400, 4095);
	endfunction

	function automatic void build_stimulus();
		int unsigned r, idx;
		bit hold;
		rsp_t e;
		// directed: header size edges, fill and exact fit, bad frees, realloc cases
		alloc_tracked(0, 0);
		alloc_tracked(63, 0);
		alloc_tracked(64, 0);
		while (live_blocks.size() > 0) free_tracked(0, 0);
		e = issue(OP_GC, 0, 0, 0, 0, 0);
		alloc_tracked(4095, 0);
		alloc_tracked(4093, 0);
		alloc_tracked(0, 0);
		alloc_tracked(0, 0);
		e = issue(OP_REALLOC, 0, 4095, 4095, 0, 0);
		e = issue(OP_FREE, 0, 0, 5, 0, 0);
		e = issue(OP_FREE, 0, 4000, 200, 0, 0);
		e = issue(OP_FREE, 1, 4095, 4095, 4095, 0);
		while (live_blocks.size() > 0) free_tracked(live_blocks.size() - 1, 0);
		e = issue(OP_GC, 0, 0, 0, 0, 0);
		alloc_tracked(100, 0);
		realloc_tracked(0, 50, 0);
		realloc_tracked(0, 4000, 0);
		realloc_tracked(0, 3000, 0);
		free_tracked(0, 1);
		e = issue(OP_GC, 0, 0, 0, 0, 0);
		// random: mostly well-formed alloc/free/realloc traffic with some noise
		for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
			hold = (i % 400) == 399;
			r = $urandom_range(0, 99);
			if (r < 7) begin
				e = issue($urandom_range(0, 3), $urandom_range(0, 1), $urandom, $urandom,
					$urandom, hold);
			end else if (r < 11) begin
				e = issue(OP_GC, $urandom_range(0, 1), $urandom, $urandom, $urandom, hold);
			end else if (live_blocks.size() > 0 && (r < 48 || live_blocks.size() > 24)) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				if ($urandom_range(0, 99) < 30) realloc_tracked(idx, pick_size(), hold);
				else free_tracked(idx, hold);
			end else if (r < 56) begin
				// realloc with no source block is a plain alloc that may coalesce
				e = issue(OP_REALLOC, 1'b0, $urandom, $urandom, pick_size(), hold);
			end else begin
				alloc_tracked(pick_size(), hold);
			end
		end
	endfunction

	// ---------------- clock, reset, driver, monitor ----------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit quiet_window(int unsigned n);
		return n >= 700 && n < 950;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit fired;
		int unsigned open_cnt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			sent_cnt <= 0;
		end else begin
			fired = req_valid && !req_stall;
			if (fired) void'(pending_q.pop_front());
			open_cnt = sent_cnt + fired - rcvd_cnt;
			if (fired) sent_cnt <= sent_cnt + 1;
			if (!req_valid || !req_stall) begin
				if (pending_q.size() > 0 && !(pending_q[0].hold && open_cnt > 0)
						&& (quiet_window(sent_cnt) || $urandom_range(0, 99) >= 37)) begin
					req_valid <= 1'b1;
					req <= pending_q[0].item;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rcvd_cnt <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rcvd_cnt <= rcvd_cnt + 1;
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected response addr=%0d ok=%0b",
							rsp.result_address, rsp.ok);
				end else begin
					e = expected_rsp_q.pop_front();
					if (rsp.result_address !== e.result_address || rsp.ok !== e.ok) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: transaction %0d: expected addr=%0d ok=%0b, got addr=%0d ok=%0b",
								rcvd_cnt, e.result_address, e.ok, rsp.result_address, rsp.ok);
					end
				end
			end
			rsp_stall <= !quiet_window(rcvd_cnt) && $urandom_range(0, 99) < 37;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout: %0d of %0d responses seen", rcvd_cnt, total_items);
			$display("tb_first_fit_heap_allocator failed");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		total_items = 0;
		for (int k = 0; k < HEAP_BYTES; k++) heap_img[k] = 8'h00;
		shape_free(0, HEAP_BYTES);
		build_stimulus();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent_cnt == total_items && expected_rsp_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_rsp_q.size() != 0) mismatches++;
		$display("ran %0d transactions: %0d allocs ok, %0d allocs refused, %0d frees, %0d reallocs ok, %0d coalesces",
			total_items, n_alloc_ok, n_alloc_fail, n_free_ok, n_realloc_ok, n_gc);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("tb_first_fit_heap_allocator passed");
		end else begin
			$display("tb_first_fit_heap_allocator failed");
		end
		$finish;
	end

endmodule

@@ first_fit_heap_allocator.f @@
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_seq.sv
hdl/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
